// File: hdl/lru_key_value_cache_unit_defines.svh
// assertion macros used by the cache rtl
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// same-cycle implication
`define LKVC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkvc assertion failed");

// next-cycle implication
`define LKVC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkvc assertion failed");

`endif

// File: hdl/lkvc_pkg.sv
package lkvc_pkg;

   localparam int unsigned DEFAULT_MAX_ENTRIES = 16;

   localparam int unsigned CFG_W          = 5;
   localparam int unsigned CAPACITY_RESET = 16;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned VALUE_W = 32;

   localparam int unsigned REQ_DATA_W = KEY_W + VALUE_W;
   localparam int unsigned REQ_USER_W = 1;
   localparam int unsigned RSP_DATA_W = VALUE_W;
   localparam int unsigned RSP_USER_W = 1;

   typedef enum logic [0:0] {
      MODE_GET = 1'b0,
      MODE_PUT = 1'b1
   } mode_type;

endpackage

// File: hdl/lru_key_value_cache_unit.sv
// Fully associative key-value cache with least-recently-used replacement. It sustains one
// request per clock while the response side does not stall: a request is registered on accept,
// its key is compared against every stored key in parallel, and when the response register can
// advance the recency ranks and valid bits are updated and the value store is read or written;
// the response is ready in the cycle after that, since the value store is a single RAM with a
// registered read. A request can therefore be accepted every cycle while rsp_tready holds. After
// reset the cache is empty at once: there is no clearing pass. The capacity register may only be
// written while the unit is idle; 0 acts as 1 and values above MAX_ENTRIES act as MAX_ENTRIES.
`include "lru_key_value_cache_unit_defines.svh"

module lru_key_value_cache_unit #(
   parameter int unsigned MAX_ENTRIES = lkvc_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   // request
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lkvc_pkg::REQ_DATA_W-1:0]  req_tdata,   // key, value
   input  logic [lkvc_pkg::REQ_USER_W-1:0]  req_tuser,   // mode
   // response
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lkvc_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // read_value
   output logic [lkvc_pkg::RSP_USER_W-1:0]  rsp_tuser,   // found
   // capacity register
   input  logic                             csr_wr_en,
   input  logic [lkvc_pkg::CFG_W-1:0]       csr_wr_data
);

   import lkvc_pkg::*;

   localparam int unsigned IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned RANK_W = IDX_W;
   localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   logic [CFG_W-1:0]        cap_ff;

   logic                    in_valid_ff;
   mode_type                in_mode_ff;
   logic [KEY_W-1:0]        in_key_ff;
   logic [VALUE_W-1:0]      in_value_ff;

   logic                    out_valid_ff;
   logic                    found_ff;

   logic [MAX_ENTRIES-1:0]  valid_ff;
   logic [MAX_ENTRIES-1:0]  valid_in;
   logic [KEY_W-1:0]        key_ff [MAX_ENTRIES];
   logic [RANK_W-1:0]       rank_ff [MAX_ENTRIES];
   logic [RANK_W-1:0]       rank_in [MAX_ENTRIES];
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;

   logic                    advance;
   logic                    do_item;
   logic                    is_put;
   logic [MAX_ENTRIES-1:0]  match;
   logic                    hit;
   logic [IDX_W-1:0]        hit_idx;
   logic [RANK_W-1:0]       hit_rank;
   logic [CMP_W-1:0]        eff_cap;
   logic                    full;
   logic [CNT_W-1:0]        last_rank;
   logic [MAX_ENTRIES-1:0]  victim;
   logic                    evict;
   logic [MAX_ENTRIES-1:0]  kept;
   logic [MAX_ENTRIES-1:0]  free_first;
   logic [MAX_ENTRIES-1:0]  ins_oh;
   logic [IDX_W-1:0]        ins_idx;
   logic [MAX_ENTRIES-1:0]  key_we;
   logic [VALUE_W-1:0]      ram_rd_data;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign do_item    = in_valid_ff && advance;
   assign is_put     = (in_mode_ff == MODE_PUT);

   // parallel key compare and lookup
   always_comb begin
      hit_idx  = '0;
      hit_rank = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == in_key_ff);
         if (match[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
      end
      hit = |match;
   end

   // effective capacity and victim selection
   always_comb begin
      eff_cap = CMP_W'(cap_ff);
      if (eff_cap == '0) begin
         eff_cap = CMP_W'(1);
      end else if (eff_cap > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end
      full      = (CMP_W'(count_ff) >= eff_cap);
      last_rank = count_ff - CNT_W'(1);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         victim[i] = valid_ff[i] && (CNT_W'(rank_ff[i]) == last_rank);
      end
      evict      = is_put && !hit && full;
      kept       = valid_ff & ~(evict ? victim : '0);
      free_first = ~valid_ff & (valid_ff + MAX_ENTRIES'(1));
      ins_oh     = evict ? victim : free_first;
      ins_idx    = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (ins_oh[i]) begin
            ins_idx = ins_idx | IDX_W'(i);
         end
      end
   end

   // next state of valid bits, ranks and fill count
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      key_we   = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (do_item) begin
         if (hit) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (match[i]) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = RANK_W'(rank_ff[i] + RANK_W'(1));
               end
            end
         end else if (is_put) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (ins_oh[i]) begin
                  rank_in[i] = '0;
               end else if (kept[i]) begin
                  rank_in[i] = RANK_W'(rank_ff[i] + RANK_W'(1));
               end
            end
            valid_in = kept | ins_oh;
            key_we   = ins_oh;
            count_in = evict ? count_ff : CNT_W'(count_ff + CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CFG_W'(CAPACITY_RESET);
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            found_ff     <= in_valid_ff && !is_put && hit;
         end
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff  <= mode_type'(req_tuser[0]);
         in_key_ff   <= req_tdata[KEY_W-1:0];
         in_value_ff <= req_tdata[REQ_DATA_W-1:KEY_W];
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_ff[i] <= rank_in[i];
         if (key_we[i]) begin
            key_ff[i] <= in_key_ff;
         end
      end
   end

   lkvc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (do_item && is_put),
      .wr_addr (hit ? hit_idx : ins_idx),
      .wr_data (in_value_ff),
      .rd_en   (do_item),
      .rd_addr (hit_idx),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = found_ff ? ram_rd_data : '0;
   assign rsp_tuser  = found_ff;

   `LKVC_ASSERT_IMP(a_count_matches_valid, clock, reset, 1'b1,
      $countones(valid_ff) == int'(count_ff))
   `LKVC_ASSERT_NXT(a_put_not_found, clock, reset, do_item && is_put, !found_ff)
   `LKVC_ASSERT_IMP(a_victim_unique, clock, reset, do_item && evict, $onehot(victim))
   `LKVC_ASSERT_IMP(a_insert_slot, clock, reset, do_item && is_put && !hit, $onehot(ins_oh))

endmodule

// File: hdl/lkvc_ram.sv
module lkvc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: verif/lru_key_value_cache_unit_tb.sv
module lru_key_value_cache_unit_tb;

   import lkvc_pkg::*;

   localparam int SLOTS           = DEFAULT_MAX_ENTRIES;
   localparam int ITEMS_PER_PHASE = 220;
   localparam int POOL_SIZE       = 40;
   localparam int PRINT_LIMIT     = 30;

   typedef struct {
      bit        found;
      bit [31:0] read_value;
   } lookup_result_type;

   // mirror of the cache contents, predicts one response per request
   class lru_cache_mirror;
      bit                slot_valid[SLOTS];
      bit [31:0]         slot_key[SLOTS];
      bit [31:0]         slot_value[SLOTS];
      bit [3:0]          slot_rank[SLOTS];
      int unsigned       held_count;
      bit [CFG_W-1:0]    capacity;
      lookup_result_type pending_lookups[$];
      int                mismatch_count;

      function new();
         foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
         end
         held_count     = 0;
         capacity       = CFG_W'(CAPACITY_RESET);
         mismatch_count = 0;
      endfunction

      function void set_capacity(bit [CFG_W-1:0] cap);
         capacity = cap;
      endfunction

      function int unsigned usable_slots();
         if (capacity == 0) begin
            return 1;
         end
         if (capacity > SLOTS) begin
            return SLOTS;
         end
         return capacity;
      endfunction

      function int pending();
         return pending_lookups.size();
      endfunction

      function void promote(int s);
         bit [3:0] old_rank;
         old_rank = slot_rank[s];
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_rank[i] < old_rank) begin
               slot_rank[i]++;
            end
         end
         slot_rank[s] = '0;
      endfunction

      function void evict_oldest();
         int       victim;
         bit [3:0] oldest;
         victim = -1;
         oldest = '0;
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_rank[i] > oldest)) begin
               victim = i;
               oldest = slot_rank[i];
            end
         end
         if (victim >= 0) begin
            slot_valid[victim] = 1'b0;
            if (held_count > 0) begin
               held_count--;
            end
         end
      endfunction

      function void note_request(mode_type mode, bit [31:0] key, bit [31:0] value);
         int                hit_slot;
         int                free_slot;
         lookup_result_type res;
         hit_slot       = -1;
         free_slot      = -1;
         res.found      = 1'b0;
         res.read_value = '0;
         for (int i = 0; i < SLOTS; i++) begin
            if (hit_slot < 0 && slot_valid[i] && slot_key[i] == key) begin
               hit_slot = i;
            end
         end
         if (hit_slot >= 0) begin
            if (mode == MODE_GET) begin
               res.found      = 1'b1;
               res.read_value = slot_value[hit_slot];
            end else begin
               slot_value[hit_slot] = value;
            end
            promote(hit_slot);
         end else if (mode == MODE_PUT) begin
            if (held_count >= usable_slots()) begin
               evict_oldest();
            end
            for (int i = 0; i < SLOTS; i++) begin
               if (free_slot < 0 && !slot_valid[i]) begin
                  free_slot = i;
               end
            end
            if (free_slot >= 0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_valid[i]) begin
                     slot_rank[i]++;
                  end
               end
               slot_valid[free_slot] = 1'b1;
               slot_key[free_slot]   = key;
               slot_value[free_slot] = value;
               slot_rank[free_slot]  = '0;
               held_count++;
            end
         end
         pending_lookups.push_back(res);
      endfunction

      task report_mismatch(string what);
         if (mismatch_count < PRINT_LIMIT) begin
            $display("ERROR: %s", what);
         end
         mismatch_count++;
      endtask

      task check_response(bit found, bit [31:0] read_value);
         lookup_result_type want;
         if (pending_lookups.size() == 0) begin
            report_mismatch($sformatf("response with no request outstanding: found=%0d value=%h",
                                      found, read_value));
         end else begin
            want = pending_lookups.pop_front();
            if (found != want.found) begin
               report_mismatch($sformatf("found: got %0d, want %0d", found, want.found));
            end
            if (read_value != want.read_value) begin
               report_mismatch($sformatf("read_value: got %h, want %h",
                                         read_value, want.read_value));
            end
         end
      endtask
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // key, value
   logic [REQ_USER_W-1:0] req_tuser   = '0;   // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // read_value
   logic [RSP_USER_W-1:0] rsp_tuser;          // found
   logic                  csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]      csr_wr_data = '0;

   lru_cache_mirror cache;
   bit              no_idle = 1'b0;
   bit [31:0]       key_pool[POOL_SIZE];

   lru_key_value_cache_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_request(input mode_type mode, input bit [31:0] key,
                               input bit [31:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {value, key};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      cache.note_request(mode, key, value);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (cache.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input bit [CFG_W-1:0] cap);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cache.set_capacity(cap);
   endtask

   task automatic random_request(input int span);
      mode_type  mode;
      bit [31:0] key;
      mode = $urandom_range(0, 1) ? MODE_PUT : MODE_GET;
      if ($urandom_range(0, 9) == 0) begin
         key = $urandom;
      end else begin
         key = key_pool[$urandom_range(0, span - 1)];
      end
      send_request(mode, key, $urandom);
   endtask

   // response side stalls independently of the request side
   initial begin
      int stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         cache.check_response(rsp_tuser[0], rsp_tdata);
      end
   end

   initial begin
      bit [CFG_W-1:0] phase_caps[9];
      int             span;
      int             pause_at;
      phase_caps = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd17, 5'd6, 5'd16, 5'd9};
      cache = new();
      foreach (key_pool[i]) begin
         key_pool[i] = $urandom;
      end
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hffff_ffff;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty cache, extreme keys and values, overwrite
      send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(MODE_PUT, 32'h0000_0000, 32'h8000_0000);
      send_request(MODE_PUT, 32'hffff_ffff, 32'h7fff_ffff);
      send_request(MODE_GET, 32'h0000_0000, 32'hffff_ffff);
      send_request(MODE_GET, 32'hffff_ffff, 32'h0000_0000);
      send_request(MODE_PUT, 32'h0000_0000, 32'hffff_ffff);
      send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(MODE_GET, 32'h0001_2345, 32'h0000_0000);
      send_request(MODE_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);

      // eviction of the least recent entry at a small capacity
      write_capacity(5'd2);
      send_request(MODE_PUT, 32'h0000_00a5, 32'h1111_1111);
      send_request(MODE_GET, 32'hffff_ffff, 32'h0000_0000);
      send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(MODE_PUT, 32'h0000_005a, 32'h2222_2222);
      send_request(MODE_GET, 32'h0000_00a5, 32'h0000_0000);
      send_request(MODE_GET, 32'h0000_005a, 32'h0000_0000);
      send_request(MODE_PUT, 32'h0000_0000, 32'hdead_beef);
      send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);

      foreach (phase_caps[p]) begin
         write_capacity(phase_caps[p]);
         span = 2 * cache.usable_slots() + 2;
         if (span > POOL_SIZE) begin
            span = POOL_SIZE;
         end
         pause_at = $urandom_range(20, ITEMS_PER_PHASE - 20);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            no_idle = ((i / 32) % 4) == 1;
            if (i == pause_at) begin
               drain_responses();
            end
            random_request(span);
         end
         no_idle = 1'b0;
      end

      drain_responses();
      repeat (8) @(posedge clock);
      if (cache.pending() != 0) begin
         cache.report_mismatch($sformatf("%0d responses never arrived", cache.pending()));
      end
      if (cache.mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/lkvc_pkg.sv
hdl/lkvc_ram.sv
hdl/lru_key_value_cache_unit.sv
verif/lru_key_value_cache_unit_tb.sv
